// ----- src/msd_pkg.sv -----
`default_nettype none

package msd_pkg;

    // Field and datapath widths
    localparam int DATA_W = 32;
    localparam int COEF_W = 31;
    localparam int STEP_W = 31;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 66;

    // Defaults for the top-level parameters
    localparam int SUBSTEPS_DEF  = 10;
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_K     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_C    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS = 2'd2;

    // Saturation bounds in the wide accumulator format
    localparam logic signed [ACC_W-1:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN = -66'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_in;
        logic        [STEP_W-1:0] step_size;
    } msd_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] position_out;
        logic signed [DATA_W-1:0] velocity_out;
        logic signed [DATA_W-1:0] accel_out;
    } msd_rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_WB,
        ST_OUT
    } msd_state_t;

    // Operation run on the shared multiplier
    typedef enum logic [2:0] {
        OP_POS,
        OP_SPRING,
        OP_DAMP,
        OP_ACC,
        OP_VEL
    } msd_op_t;

    function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
        return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_data(input logic signed [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = S32_MAX[DATA_W-1:0];
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/mass_spring_damper_euler_step.sv -----
`default_nettype none

// Mass-spring-damper stepper, semi-implicit Euler, fixed point with FRAC_BITS
// fraction bits. Each request beat carries a force and a step length; the block
// splits the step into SUBSTEPS substeps (h = step_size / SUBSTEPS, truncated),
// advances position then velocity in each, and returns one beat with the new
// position, velocity and the acceleration of the final state. Position and
// velocity persist across beats (reset: 1.0 and 0). Products round toward minus
// infinity; position, velocity, net force and acceleration saturate to 32 bits.
// Sequence: the request beat is taken in ST_IDLE, then ST_DIV forms h by
// multiplying with a rounded-up constant reciprocal, then every product goes
// through one shared 32x31 multiplier (ST_MUL forms it, ST_WB writes it back),
// five products per substep plus three for the final acceleration, then ST_OUT
// loads the response register once it is free and the sequencer returns to
// ST_IDLE. req_stall is high for the whole item; the response sits in an output
// register so the next request can be taken while it waits. Coefficients are
// written through cfg_*; the user must keep such writes to idle, as the block
// has no check of its own.
module mass_spring_damper_euler_step #(
    parameter int SUBSTEPS  = msd_pkg::SUBSTEPS_DEF,
    parameter int FRAC_BITS = msd_pkg::FRAC_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  req_valid,
    output logic                                 req_stall,
    input  msd_pkg::msd_req_t                    req_data,
    output logic                                 rsp_valid,
    input  wire                                  rsp_stall,
    output msd_pkg::msd_rsp_t                    rsp_data,
    input  wire                                  cfg_we,
    input  wire  [msd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [msd_pkg::COEF_W-1:0]           cfg_data
);

    localparam int SUB_W    = $clog2(SUBSTEPS + 1);
    localparam int RECIP_W  = msd_pkg::STEP_W + 2;
    localparam int RECIP_SH = msd_pkg::STEP_W + $clog2(SUBSTEPS);
    // ceil(2^RECIP_SH / SUBSTEPS): exact quotient for every 31-bit step
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SH) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS));
    localparam logic [msd_pkg::COEF_W-1:0] ONE = msd_pkg::COEF_W'(1) << FRAC_BITS;

    // Configuration registers
    logic [msd_pkg::COEF_W-1:0] k_reg, c_reg, im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= ONE;
            c_reg  <= ONE;
            im_reg <= ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msd_pkg::CFG_SPRING_K:     k_reg  <= cfg_data;
                msd_pkg::CFG_DAMPING_C:    c_reg  <= cfg_data;
                msd_pkg::CFG_INVERSE_MASS: im_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Sequencer and datapath registers
    msd_pkg::msd_state_t state_reg, state_next;
    msd_pkg::msd_op_t    op_reg, op_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic                final_reg, final_next;
    logic [msd_pkg::STEP_W-1:0] quo_reg, quo_next;
    logic signed [msd_pkg::DATA_W-1:0] force_reg, force_next;
    logic signed [msd_pkg::DATA_W-1:0] pos_reg, pos_next;
    logic signed [msd_pkg::DATA_W-1:0] vel_reg, vel_next;
    logic signed [msd_pkg::DATA_W-1:0] net_reg, net_next;
    logic signed [msd_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic signed [msd_pkg::PROD_W-1:0] spr_reg, spr_next;
    logic signed [msd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                rsp_valid_reg, rsp_valid_next;
    msd_pkg::msd_rsp_t   rsp_reg, rsp_next;

    // Shared multiplier operands
    logic signed [msd_pkg::DATA_W-1:0] mul_a;
    logic        [msd_pkg::COEF_W-1:0] mul_b;
    logic signed [msd_pkg::PROD_W-1:0] prod_sh;
    logic        [msd_pkg::PROD_W-1:0] h_prod;
    logic        [msd_pkg::PROD_W-1:0] h_quot;
    logic                              rsp_free;

    assign req_stall = (state_reg != msd_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign prod_sh = prod_reg >>> FRAC_BITS;

    // Step length times the constant reciprocal, quotient in the upper bits
    assign h_prod = {{(msd_pkg::PROD_W - msd_pkg::STEP_W){1'b0}}, quo_reg} *
                    {{(msd_pkg::PROD_W - RECIP_W){1'b0}}, RECIP};
    assign h_quot = h_prod >> RECIP_SH;

    // Operand select
    always_comb
    begin
        unique case (op_reg)
            msd_pkg::OP_POS:    begin mul_a = vel_reg; mul_b = quo_reg; end
            msd_pkg::OP_SPRING: begin mul_a = pos_reg; mul_b = k_reg;   end
            msd_pkg::OP_DAMP:   begin mul_a = vel_reg; mul_b = c_reg;   end
            msd_pkg::OP_ACC:    begin mul_a = net_reg; mul_b = im_reg;  end
            msd_pkg::OP_VEL:    begin mul_a = acc_reg; mul_b = quo_reg; end
            default:            begin mul_a = vel_reg; mul_b = quo_reg; end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = msd_pkg::ST_DIV;
                end
            end
            msd_pkg::ST_DIV:
            begin
                state_next = msd_pkg::ST_MUL;
            end
            msd_pkg::ST_MUL:
            begin
                state_next = msd_pkg::ST_WB;
            end
            msd_pkg::ST_WB:
            begin
                if (op_reg == msd_pkg::OP_ACC && final_reg)
                begin
                    state_next = msd_pkg::ST_OUT;
                end
                else
                begin
                    state_next = msd_pkg::ST_MUL;
                end
            end
            msd_pkg::ST_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = msd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output next values
    always_comb
    begin
        op_next        = op_reg;
        sub_next       = sub_reg;
        final_next     = final_reg;
        quo_next       = quo_reg;
        force_next     = force_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        net_next       = net_reg;
        acc_next       = acc_reg;
        spr_next       = spr_reg;
        prod_next      = prod_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                force_next = req_data.force_in;
                quo_next   = req_data.step_size;
            end
            msd_pkg::ST_DIV:
            begin
                // h = step_size / SUBSTEPS, left in quo_reg
                quo_next   = h_quot[msd_pkg::STEP_W-1:0];
                op_next    = msd_pkg::OP_POS;
                sub_next   = '0;
                final_next = 1'b0;
            end
            msd_pkg::ST_MUL:
            begin
                prod_next = msd_pkg::PROD_W'(
                    $signed({{(msd_pkg::PROD_W - msd_pkg::DATA_W){mul_a[msd_pkg::DATA_W-1]}},
                             mul_a}) *
                    $signed({{(msd_pkg::PROD_W - msd_pkg::COEF_W){1'b0}}, mul_b}));
            end
            msd_pkg::ST_WB:
            begin
                unique case (op_reg)
                    msd_pkg::OP_POS:
                    begin
                        pos_next = msd_pkg::sat32(msd_pkg::ext_data(pos_reg) +
                                                  msd_pkg::ext_prod(prod_sh));
                        op_next  = msd_pkg::OP_SPRING;
                    end
                    msd_pkg::OP_SPRING:
                    begin
                        spr_next = prod_sh;
                        op_next  = msd_pkg::OP_DAMP;
                    end
                    msd_pkg::OP_DAMP:
                    begin
                        // net force = force - spring term - damping term
                        net_next = msd_pkg::sat32(msd_pkg::ext_data(force_reg) -
                                                  msd_pkg::ext_prod(spr_reg) -
                                                  msd_pkg::ext_prod(prod_sh));
                        op_next  = msd_pkg::OP_ACC;
                    end
                    msd_pkg::OP_ACC:
                    begin
                        acc_next = msd_pkg::sat32(msd_pkg::ext_prod(prod_sh));
                        op_next  = msd_pkg::OP_VEL;
                    end
                    msd_pkg::OP_VEL:
                    begin
                        vel_next = msd_pkg::sat32(msd_pkg::ext_data(vel_reg) +
                                                  msd_pkg::ext_prod(prod_sh));
                        sub_next = sub_reg + SUB_W'(1);
                        if (sub_reg == SUB_W'(SUBSTEPS - 1))
                        begin
                            // last substep done: one more acceleration pass
                            final_next = 1'b1;
                            op_next    = msd_pkg::OP_SPRING;
                        end
                        else
                        begin
                            op_next = msd_pkg::OP_POS;
                        end
                    end
                    default:
                    begin
                        op_next = msd_pkg::OP_POS;
                    end
                endcase
            end
            msd_pkg::ST_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_next.position_out = pos_reg;
                    rsp_next.velocity_out = vel_reg;
                    rsp_next.accel_out    = acc_reg;
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
                op_next = msd_pkg::OP_POS;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msd_pkg::ST_IDLE;
            op_reg        <= msd_pkg::OP_POS;
            sub_reg       <= '0;
            final_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pos_reg       <= msd_pkg::DATA_W'(ONE);
            vel_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sub_reg       <= sub_next;
            final_reg     <= final_next;
            rsp_valid_reg <= rsp_valid_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        force_reg <= force_next;
        net_reg   <= net_next;
        acc_reg   <= acc_next;
        spr_reg   <= spr_next;
        prod_reg  <= prod_next;
        rsp_reg   <= rsp_next;
    end

endmodule

`default_nettype wire

// ----- dv/msd_motion_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, response and register-write ports of the stepper.
// It keeps its own copy of the coefficients and of the position and velocity state,
// predicts one response per accepted request beat, and compares responses in order.
module msd_motion_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                req_valid,
    input  wire                                req_stall,
    input  msd_pkg::msd_req_t                  req_data,
    input  wire                                rsp_valid,
    input  wire                                rsp_stall,
    input  msd_pkg::msd_rsp_t                  rsp_data,
    input  wire                                cfg_we,
    input  wire  [msd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [msd_pkg::COEF_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 pending
);

    localparam int     SUBSTEPS   = msd_pkg::SUBSTEPS_DEF;
    localparam int     FRAC_BITS  = msd_pkg::FRAC_BITS_DEF;
    localparam int     REPORT_MAX = 10;
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;

    // Coefficients and plant state as the block should hold them
    logic        [msd_pkg::COEF_W-1:0] spring_k;
    logic        [msd_pkg::COEF_W-1:0] damping_c;
    logic        [msd_pkg::COEF_W-1:0] inverse_mass;
    logic signed [msd_pkg::DATA_W-1:0] position;
    logic signed [msd_pkg::DATA_W-1:0] velocity;

    msd_pkg::msd_rsp_t motion_q[$];
    msd_pkg::msd_rsp_t expected_rsp;
    msd_pkg::msd_rsp_t predicted_rsp;

    // Exact product, then floor by the fraction width
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [msd_pkg::DATA_W-1:0] clamp32(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX[msd_pkg::DATA_W-1:0];
        if (v < WORD_MIN)
            return WORD_MIN[msd_pkg::DATA_W-1:0];
        return v[msd_pkg::DATA_W-1:0];
    endfunction

    // Net force clamps before it is scaled by the inverse mass
    function automatic logic signed [msd_pkg::DATA_W-1:0] accel_of_state(input longint f,
                                                                         input longint p,
                                                                         input longint v);
        longint net;
        net = f - fx_mul(p, longint'(spring_k)) - fx_mul(v, longint'(damping_c));
        net = clamp32(net);
        return clamp32(fx_mul(net, longint'(inverse_mass)));
    endfunction

    // One communication step: position first, then velocity from the new position
    task automatic step_motion(input msd_pkg::msd_req_t beat,
                               output msd_pkg::msd_rsp_t result);
        longint                            f;
        longint                            h;
        logic signed [msd_pkg::DATA_W-1:0] acc;
        f = longint'($signed(beat.force_in));
        h = longint'(beat.step_size) / SUBSTEPS;
        for (int s = 0; s < SUBSTEPS; s++)
        begin
            position = clamp32(position + fx_mul(velocity, h));
            acc      = accel_of_state(f, position, velocity);
            velocity = clamp32(velocity + fx_mul(acc, h));
        end
        acc = accel_of_state(f, position, velocity);
        result.position_out = position;
        result.velocity_out = velocity;
        result.accel_out    = acc;
    endtask

    task automatic check_field(input string name,
                               input logic signed [msd_pkg::DATA_W-1:0] expv,
                               input logic signed [msd_pkg::DATA_W-1:0] actv);
        if (expv !== actv)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: %s mismatch: expected %0d (%08h), got %0d (%08h)",
                         $time, name, expv, expv, actv, actv);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_k     = 31'd65536;
            damping_c    = 31'd65536;
            inverse_mass = 31'd65536;
            position     = 32'sd65536;
            velocity     = '0;
            motion_q.delete();
            pending      = 0;
            fail_count   = 0;
        end
        else
        begin
            // Register writes; an unknown index leaves everything alone
            if (cfg_we)
            begin
                case (cfg_index)
                    msd_pkg::CFG_SPRING_K:     spring_k     = cfg_data;
                    msd_pkg::CFG_DAMPING_C:    damping_c    = cfg_data;
                    msd_pkg::CFG_INVERSE_MASS: inverse_mass = cfg_data;
                    default:                   ;
                endcase
            end

            // Response side first so a same-edge request cannot pair with it
            if (rsp_valid && !rsp_stall)
            begin
                if (motion_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: response beat with nothing outstanding: %0d %0d %0d",
                                 $time, rsp_data.position_out, rsp_data.velocity_out,
                                 rsp_data.accel_out);
                end
                else
                begin
                    expected_rsp = motion_q.pop_front();
                    check_field("position", expected_rsp.position_out, rsp_data.position_out);
                    check_field("velocity", expected_rsp.velocity_out, rsp_data.velocity_out);
                    check_field("accel", expected_rsp.accel_out, rsp_data.accel_out);
                end
            end

            if (req_valid && !req_stall)
            begin
                step_motion(req_data, predicted_rsp);
                motion_q.push_back(predicted_rsp);
            end

            pending = motion_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    typedef logic        [msd_pkg::STEP_W-1:0] step_t;
    typedef logic        [msd_pkg::COEF_W-1:0] coef_t;
    typedef logic signed [msd_pkg::DATA_W-1:0] force_t;

    localparam logic [msd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam coef_t            Q_ONE         = 31'd65536;
    localparam coef_t            COEF_MAX      = '1;
    localparam step_t            STEP_MAX      = '1;
    localparam int               IDLE_LIMIT    = 4000;
    localparam int               DRAIN_CYCLES  = 300;
    localparam int               RANDOM_PHASES = 6;
    localparam int               PHASE_ITEMS   = 214;

    logic                              clk;
    logic                              rst_n        = 1'b0;
    logic                              req_valid    = 1'b0;
    logic                              req_stall;
    msd_pkg::msd_req_t                 req_data     = '0;
    logic                              rsp_valid;
    logic                              rsp_stall    = 1'b0;
    msd_pkg::msd_rsp_t                 rsp_data;
    logic                              cfg_we       = 1'b0;
    logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index    = '0;
    coef_t                             cfg_data     = '0;

    int fail_count;
    int pending;
    int req_idle_pct  = 24;
    int rsp_idle_pct  = 83;
    int quiet_cycles  = 0;

    mass_spring_damper_euler_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msd_motion_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
    end

    // Watchdog on stretches with no beat moving
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Entered and left at a falling edge; valid stays up if the next beat follows at once
    task automatic send_beat(input force_t force_v, input step_t step_v);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{force_in: force_v, step_size: step_v};
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Drain the block, then load all coefficients plus a stray write to the spare index
    task automatic write_coefs(input coef_t k, input coef_t c, input coef_t m);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= msd_pkg::CFG_SPRING_K;
        cfg_data  <= k;
        @(negedge clk);
        cfg_index <= msd_pkg::CFG_DAMPING_C;
        cfg_data  <= c;
        @(negedge clk);
        cfg_index <= msd_pkg::CFG_INVERSE_MASS;
        cfg_data  <= m;
        @(negedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= coef_t'($urandom);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int     pick;
        force_t force_v;
        step_t  step_v;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes and short steps at the reset coefficients
        send_beat(32'sd0, Q_ONE);
        send_beat(32'sh7fffffff, '0);
        send_beat(32'sh80000000, 31'd9);
        send_beat(32'sd0, 31'd10);
        send_beat(-32'sd65536, STEP_MAX);
        send_beat(32'sh80000000, STEP_MAX);
        send_beat(32'sh7fffffff, STEP_MAX);

        // Stiff spring, no damping, huge inverse mass: net force and accel clamp
        write_coefs(COEF_MAX, '0, COEF_MAX);
        send_beat(32'sh7fffffff, Q_ONE);
        send_beat(32'sh80000000, 31'd655);
        send_beat(32'sd0, 31'd5);

        // Zero inverse mass: no acceleration at all
        write_coefs(Q_ONE, COEF_MAX, '0);
        send_beat(32'sh7fffffff, Q_ONE);
        send_beat(32'sh80000000, STEP_MAX);

        // Moderately damped settings to pull the state back toward rest
        write_coefs(Q_ONE << 2, Q_ONE << 1, Q_ONE);
        repeat (4) send_beat(32'sd0, Q_ONE);

        // Random phases: sender-light, receiver-light, then no idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase / 2)
                0:       begin req_idle_pct = 24; rsp_idle_pct = 83; end
                1:       begin req_idle_pct = 83; rsp_idle_pct = 24; end
                default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
            endcase

            if (phase == 0)
                write_coefs(Q_ONE, Q_ONE, Q_ONE);
            else if (phase == 3)
                write_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
            else
                write_coefs(coef_t'($urandom_range(0, 8 * Q_ONE)),
                            coef_t'($urandom_range(0, 4 * Q_ONE)),
                            coef_t'($urandom_range(0, 4 * Q_ONE)));

            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // physically sensible: moderate force, step up to a few seconds
                    force_v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                    step_v  = step_t'($urandom_range(0, 4 * Q_ONE));
                end
                else if (pick < 85)
                begin
                    // steps around the point where the substep length becomes zero
                    force_v = $urandom;
                    step_v  = step_t'($urandom_range(0, 20));
                end
                else
                begin
                    force_v = $urandom;
                    step_v  = step_t'($urandom);
                end
                send_beat(force_v, step_v);
            end
        end

        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
